FILE: hdl/tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the TLS server name extractor: parse phases, constants,
// and the structs for one payload byte and one result. No dependencies.
package tse_pkg;

    // Parse phase of the ClientHello walker.
    typedef enum logic [3:0] {
        PH_REC       = 4'd0,
        PH_HS        = 4'd1,
        PH_FIXED     = 4'd2,
        PH_SID       = 4'd3,
        PH_CSLEN     = 4'd4,
        PH_CS        = 4'd5,
        PH_COMPLEN   = 4'd6,
        PH_COMP      = 4'd7,
        PH_EXTLEN    = 4'd8,
        PH_EXTHDR    = 4'd9,
        PH_EXTSKIP   = 4'd10,
        PH_LISTLEN   = 4'd11,
        PH_ENTRYHDR  = 4'd12,
        PH_ENTRYSKIP = 4'd13,
        PH_NAME      = 4'd14,
        PH_STOP      = 4'd15
    } t_phase;

    localparam logic [7:0]  TLS_HANDSHAKE    = 8'd22;
    localparam logic [7:0]  HS_CLIENT_HELLO  = 8'd1;
    localparam logic [15:0] SERVER_NAME_EXT  = 16'h0000;
    localparam logic [7:0]  HOST_NAME_TYPE   = 8'd0;
    // Version and random, plus one for the session id length byte.
    localparam logic [15:0] FIXED_SKIP       = 16'd35;
    localparam logic [7:0]  MAX_NAME_RESET   = 8'd255;

    // One payload byte as it enters the block.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] payload_length;
        logic        first_byte;
    } t_item;

    // One result.
    typedef struct packed {
        logic [7:0] name_byte;
        logic       byte_valid;
        logic       last;
        logic       found;
    } t_result;

endpackage
`default_nettype wire

FILE: hdl/tse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for payload bytes in and results out.
// Depends on nothing else.
interface tse_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic        first_byte;

    modport source (output valid, data_byte, payload_length, first_byte, input ready);
    modport sink   (input valid, data_byte, payload_length, first_byte, output ready);
endinterface

interface tse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       last;
    logic       found;

    modport source (output valid, name_byte, byte_valid, last, found, input ready);
    modport sink   (input valid, name_byte, byte_valid, last, found, output ready);
endinterface
`default_nettype wire

FILE: hdl/tse_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// Input register: holds one accepted payload byte until the parser takes it.
// Depends on tse_pkg.
module tse_in_reg
    import tse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_adv,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // Room when empty or when the held byte moves on this cycle.
    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tse_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ClientHello walker: parse state, the name length limit register, and the
// one-byte step that yields at most one result. Depends on tse_pkg.
module tse_parser
    import tse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_step,
    input  wire t_item      i_item,
    output logic            o_res_valid,
    output t_result         o_res
);

    logic [7:0]  r_max_name;
    logic [15:0] r_pos;
    t_phase      r_phase;
    logic [16:0] r_rec_end;
    logic [23:0] r_hs_rem;
    logic [15:0] r_skip;
    logic [7:0]  r_len_hi;
    logic [16:0] r_ext_end;
    logic [16:0] r_cur_ext_end;
    logic [15:0] r_name_rem;
    logic        r_finished;

    logic [15:0] n_pos;
    t_phase      n_phase;
    logic [16:0] n_rec_end;
    logic [23:0] n_hs_rem;
    logic [15:0] n_skip;
    logic [7:0]  n_len_hi;
    logic [16:0] n_ext_end;
    logic [16:0] n_cur_ext_end;
    logic [15:0] n_name_rem;
    logic        n_finished;

    // State as seen by this byte: a first byte restarts the parser.
    logic [15:0] c_pos;
    t_phase      c_phase;
    logic [16:0] c_rec_end;
    logic [23:0] c_hs_rem;
    logic [15:0] c_skip;
    logic [7:0]  c_len_hi;
    logic [16:0] c_ext_end;
    logic [16:0] c_cur_ext_end;
    logic [15:0] c_name_rem;
    logic        c_finished;

    logic [7:0]  b;
    logic [16:0] plen;
    logic [16:0] np;
    logic [15:0] len16;
    logic [16:0] np_len;
    logic [15:0] skip_dec;
    logic [23:0] hs_full;
    logic [23:0] hr;
    logic [15:0] name_cnt;
    logic [15:0] name_dec;
    logic        name_last;

    assign b     = i_item.data_byte;
    assign plen  = {1'b0, i_item.payload_length};

    always_comb begin
        if (i_item.first_byte) begin
            c_pos = '0; c_phase = PH_REC; c_rec_end = '0; c_hs_rem = '0;
            c_skip = '0; c_len_hi = '0; c_ext_end = '0; c_cur_ext_end = '0;
            c_name_rem = '0; c_finished = 1'b0;
        end else begin
            c_pos = r_pos; c_phase = r_phase; c_rec_end = r_rec_end;
            c_hs_rem = r_hs_rem; c_skip = r_skip; c_len_hi = r_len_hi;
            c_ext_end = r_ext_end; c_cur_ext_end = r_cur_ext_end;
            c_name_rem = r_name_rem; c_finished = r_finished;
        end
    end

    assign np       = {1'b0, c_pos} + 17'd1;
    assign len16    = {c_len_hi, b};
    assign np_len   = np + {1'b0, len16};
    assign skip_dec = (c_skip != 16'd0) ? c_skip - 16'd1 : c_skip;
    assign hs_full  = c_hs_rem | {16'd0, b};
    assign name_cnt = (len16 < {8'd0, r_max_name}) ? len16 : {8'd0, r_max_name};
    assign name_dec = (c_name_rem != 16'd0) ? c_name_rem - 16'd1 : c_name_rem;
    assign name_last = (name_dec == 16'd0) || (np == plen);

    // Handshake body counter after this byte's decrement.
    always_comb begin
        hr = c_hs_rem;
        if (c_phase >= PH_FIXED && c_phase <= PH_EXTLEN && c_hs_rem != 24'd0) begin
            hr = c_hs_rem - 24'd1;
        end
    end

    // One parser step.
    always_comb begin
        n_pos = (c_pos != 16'hFFFF) ? c_pos + 16'd1 : c_pos;
        n_phase = c_phase; n_rec_end = c_rec_end; n_hs_rem = c_hs_rem;
        n_skip = c_skip; n_len_hi = c_len_hi; n_ext_end = c_ext_end;
        n_cur_ext_end = c_cur_ext_end; n_name_rem = c_name_rem;
        n_finished = c_finished;
        o_res_valid = 1'b0;
        o_res = '0;

        if ({1'b0, c_pos} < plen && !c_finished) begin
            n_hs_rem = hr;
            unique case (c_phase)
                PH_REC: begin
                    if (c_pos == 16'd0 && b != TLS_HANDSHAKE) begin
                        n_phase = PH_STOP;
                    end else if (c_pos == 16'd3) begin
                        n_len_hi = b;
                    end else if (c_pos == 16'd4) begin
                        if ({1'b0, len16} + 17'd5 > plen || len16 < 16'd4) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_rec_end = {1'b0, len16} + 17'd5;
                            n_phase = PH_HS;
                        end
                    end
                end
                PH_HS: begin
                    if (c_pos == 16'd5 && b != HS_CLIENT_HELLO) begin
                        n_phase = PH_STOP;
                    end else if (c_pos == 16'd6) begin
                        n_hs_rem = {b, 16'd0};
                    end else if (c_pos == 16'd7) begin
                        n_hs_rem = c_hs_rem | {8'd0, b, 8'd0};
                    end else if (c_pos == 16'd8) begin
                        n_hs_rem = hs_full;
                        if ({1'b0, hs_full} + 25'd4 > {8'd0, c_rec_end - 17'd5}
                                || hs_full < {8'd0, FIXED_SKIP}) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_FIXED;
                            n_skip = FIXED_SKIP;
                        end
                    end
                end
                PH_FIXED: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (hr < {16'd0, b}) begin
                            n_phase = PH_STOP;
                        end else if (b == 8'd0) begin
                            n_phase = (hr < 24'd2) ? PH_STOP : PH_CSLEN;
                            n_skip = (hr < 24'd2) ? skip_dec : 16'd0;
                        end else begin
                            n_phase = PH_SID;
                            n_skip = {8'd0, b};
                        end
                    end
                end
                PH_SID, PH_CS, PH_COMP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        priority if (c_phase == PH_SID) begin
                            n_phase = (hr < 24'd2) ? PH_STOP : PH_CSLEN;
                        end else if (c_phase == PH_CS) begin
                            n_phase = (hr < 24'd1) ? PH_STOP : PH_COMPLEN;
                        end else begin
                            n_phase = (hr < 24'd2) ? PH_STOP : PH_EXTLEN;
                        end
                    end
                end
                PH_CSLEN: begin
                    if (c_skip == 16'd0) begin
                        n_len_hi = b;
                        n_skip = 16'd1;
                    end else if (hr < {8'd0, len16}) begin
                        n_phase = PH_STOP;
                    end else if (len16 == 16'd0) begin
                        if (hr < 24'd1) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_COMPLEN;
                            n_skip = 16'd0;
                        end
                    end else begin
                        n_phase = PH_CS;
                        n_skip = len16;
                    end
                end
                PH_COMPLEN: begin
                    if (hr < {16'd0, b}) begin
                        n_phase = PH_STOP;
                    end else if (b == 8'd0) begin
                        if (hr < 24'd2) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_EXTLEN;
                            n_skip = 16'd0;
                        end
                    end else begin
                        n_phase = PH_COMP;
                        n_skip = {8'd0, b};
                    end
                end
                PH_EXTLEN: begin
                    if (c_skip == 16'd0) begin
                        n_len_hi = b;
                        n_skip = 16'd1;
                    end else if (hr < {8'd0, len16}) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_ext_end = np_len;
                        if (np + 17'd4 > np_len) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_EXTHDR;
                            n_skip = 16'd0;
                        end
                    end
                end
                PH_EXTHDR: begin
                    if (c_skip == 16'd0 || c_skip == 16'd2) begin
                        n_len_hi = b;
                        n_skip = c_skip + 16'd1;
                    end else if (c_skip == 16'd1) begin
                        n_name_rem = len16;
                        n_skip = 16'd2;
                    end else if (np_len > c_ext_end) begin
                        n_phase = PH_STOP;
                    end else if (c_name_rem == SERVER_NAME_EXT) begin
                        if (len16 < 16'd2) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_cur_ext_end = np_len;
                            n_phase = PH_LISTLEN;
                            n_skip = 16'd0;
                        end
                    end else if (len16 == 16'd0) begin
                        if (np + 17'd4 > c_ext_end) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_EXTHDR;
                            n_skip = 16'd0;
                        end
                    end else begin
                        n_phase = PH_EXTSKIP;
                        n_skip = len16;
                    end
                end
                PH_EXTSKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (np + 17'd4 > c_ext_end) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_EXTHDR;
                        end
                    end
                end
                PH_LISTLEN: begin
                    n_skip = c_skip + 16'd1;
                    if (c_skip + 16'd1 >= 16'd2) begin
                        if (np + 17'd3 > c_cur_ext_end) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_ENTRYHDR;
                            n_skip = 16'd0;
                        end
                    end
                end
                PH_ENTRYHDR: begin
                    if (c_skip == 16'd0) begin
                        n_name_rem = {8'd0, b};
                        n_skip = 16'd1;
                    end else if (c_skip == 16'd1) begin
                        n_len_hi = b;
                        n_skip = 16'd2;
                    end else if (np_len > c_cur_ext_end) begin
                        n_phase = PH_STOP;
                    end else if (c_name_rem == {8'd0, HOST_NAME_TYPE}) begin
                        if (name_cnt == 16'd0) begin
                            // Empty host name: one found result without a byte.
                            o_res_valid = 1'b1;
                            o_res.last = 1'b1;
                            o_res.found = 1'b1;
                            n_finished = 1'b1;
                            n_phase = PH_STOP;
                        end else begin
                            n_name_rem = name_cnt;
                            n_phase = PH_NAME;
                        end
                    end else if (len16 == 16'd0) begin
                        if (np + 17'd3 > c_cur_ext_end) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_ENTRYHDR;
                            n_skip = 16'd0;
                        end
                    end else begin
                        n_phase = PH_ENTRYSKIP;
                        n_skip = len16;
                    end
                end
                PH_ENTRYSKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (np + 17'd3 > c_cur_ext_end) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_ENTRYHDR;
                        end
                    end
                end
                PH_NAME: begin
                    n_name_rem = name_dec;
                    o_res_valid = 1'b1;
                    o_res.name_byte = b;
                    o_res.byte_valid = 1'b1;
                    o_res.last = name_last;
                    o_res.found = 1'b1;
                    if (name_last) begin
                        n_finished = 1'b1;
                        n_phase = PH_STOP;
                    end
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase

            // Final payload byte with nothing found.
            if (!o_res_valid && np == plen) begin
                o_res_valid = 1'b1;
                o_res.last = 1'b1;
                n_finished = 1'b1;
                n_phase = PH_STOP;
            end
        end
    end

    // Name length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name <= MAX_NAME_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_name <= i_cfg_wr_data;
        end
    end

    // Parse state, advanced once per byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_phase <= PH_REC; r_rec_end <= '0; r_hs_rem <= '0;
            r_skip <= '0; r_len_hi <= '0; r_ext_end <= '0; r_cur_ext_end <= '0;
            r_name_rem <= '0; r_finished <= 1'b0;
        end else if (i_step) begin
            r_pos <= n_pos; r_phase <= n_phase; r_rec_end <= n_rec_end;
            r_hs_rem <= n_hs_rem; r_skip <= n_skip; r_len_hi <= n_len_hi;
            r_ext_end <= n_ext_end; r_cur_ext_end <= n_cur_ext_end;
            r_name_rem <= n_name_rem; r_finished <= n_finished;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tse_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register: holds one result until the sink takes it.
// Depends on tse_pkg.
module tse_out_reg
    import tse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_res,
    output logic         o_can_take
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result leaves this cycle.
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tls_sni_extractor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// TLS server name extractor. Takes a TCP payload one byte per request and
// walks a ClientHello to the first host_name entry of the server_name
// extension, streaming that name out (cut to the configured length) with
// the last byte marked, or one not-found result on the final payload byte.
// A new byte is taken every clock cycle while the result register has
// room; each byte passes an input register, a combinational parser step
// and then a result register, which holds any result that the byte yields.
// Depends on tse_pkg, tse_if, tse_in_reg, tse_parser, tse_out_reg.
module tls_sni_extractor_unit
    import tse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    tse_in_if.sink          i_in,
    tse_out_if.source       o_out
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    in_ready;
    logic    step;
    logic    out_can_take;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    out_valid;

    assign in_item.data_byte      = i_in.data_byte;
    assign in_item.payload_length = i_in.payload_length;
    assign in_item.first_byte     = i_in.first_byte;
    assign i_in.ready             = in_ready;

    // The held byte steps the parser when the result register has room.
    assign step = held_valid && out_can_take;

    tse_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .i_adv   (step),
        .o_ready (in_ready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    tse_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (held_item),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    tse_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && res_valid),
        .i_res      (res),
        .i_ready    (o_out.ready),
        .o_valid    (out_valid),
        .o_res      (out_res),
        .o_can_take (out_can_take)
    );

    assign o_out.valid      = out_valid;
    assign o_out.name_byte  = out_res.name_byte;
    assign o_out.byte_valid = out_res.byte_valid;
    assign o_out.last       = out_res.last;
    assign o_out.found      = out_res.found;

endmodule
`default_nettype wire
